[rtl/msf_pkg.sv]
// Shared types, constants and helpers for the masked span fill block.
// No dependencies; imported by every module of the block.
`default_nettype none

package msf_pkg;

   localparam int ROW_W    = 8;
   localparam int X_W      = 12;
   localparam int WORD_W   = 32;
   localparam int ADDR_W   = 14;
   localparam int STRIDE_W = 7;
   localparam int CNT_W    = 4;

   localparam logic [CNT_W-1:0]    MAX_WRITES   = CNT_W'(13);
   localparam logic [WORD_W-1:0]   FULL_MASK    = 32'hffff_ffff;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(13);

   // one entry in the span queue: everything the back end needs to walk a span
   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [CNT_W-1:0]  last_idx;
      logic [WORD_W-1:0] first_mask;
      logic [WORD_W-1:0] last_mask;
      logic [WORD_W-1:0] fill;
   } span_desc_type;

   function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] v);
      byte_swap = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

`default_nettype wire

[rtl/msf_front.sv]
// Front end: takes span words, clips and classifies them, builds queue entries.
// Holds the row stride register. Depends on msf_pkg.
`default_nettype none

module msf_front
   import msf_pkg::*;
#(
   parameter int SCREEN_WIDTH = 400,
   parameter int SCREEN_ROWS  = 240
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   input  wire logic                  queue_full,
   input  wire logic [ROW_W-1:0]      req_row_index,
   input  wire logic signed [X_W-1:0] req_x_start,
   input  wire logic signed [X_W-1:0] req_x_end,
   input  wire logic [WORD_W-1:0]     req_fill_word,
   input  wire logic                  csr_valid,
   input  wire logic [STRIDE_W-1:0]   csr_data,
   output span_desc_type              desc,
   output logic                       desc_push
);

   localparam logic signed [X_W:0] WIDTH_S = (X_W+1)'(SCREEN_WIDTH);

   logic [STRIDE_W-1:0]      stride_ff, stride_in;
   logic signed [X_W:0]      xs_ext, xe_ext;
   logic                     row_ok, off_screen, reversed, has_writes;
   logic [X_W-1:0]           xs_clip, xe_clip;
   logic [4:0]               sbit, ebit;
   logic [X_W-6:0]           col, ecol, last_col, total;
   logic                     single;
   logic [WORD_W-1:0]        smask, emask, single_mask;
   logic [ROW_W+STRIDE_W-1:0] row_base;

   assign stride_in = csr_valid ? csr_data : stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= STRIDE_RESET;
      end else begin
         stride_ff <= stride_in;
      end
   end

   always_comb begin
      xs_ext     = {req_x_start[X_W-1], req_x_start};
      xe_ext     = {req_x_end[X_W-1], req_x_end};
      row_ok     = int'(req_row_index) < SCREEN_ROWS;
      off_screen = req_x_end[X_W-1] || (xs_ext >= WIDTH_S);
      xs_clip    = req_x_start[X_W-1] ? '0 : X_W'(req_x_start);
      xe_clip    = (xe_ext > WIDTH_S) ? X_W'(WIDTH_S) : X_W'(req_x_end);
      reversed   = xs_clip > xe_clip;
      has_writes = row_ok && !off_screen && !reversed;

      sbit   = xs_clip[4:0];
      ebit   = xe_clip[4:0];
      col    = xs_clip[X_W-1:5];
      ecol   = xe_clip[X_W-1:5];
      single = (col == ecol);

      // MSB-first pixels: start mask keeps bit sbit onwards, end mask the top ebit bits
      smask = byte_swap(FULL_MASK >> sbit);
      emask = byte_swap(~(FULL_MASK >> ebit));

      if (sbit != 5'd0 && ebit != 5'd0) begin
         single_mask = smask & emask;
      end else if (sbit != 5'd0) begin
         single_mask = smask;
      end else if (ebit != 5'd0) begin
         single_mask = emask;
      end else begin
         single_mask = '0;
      end

      last_col = (ebit != 5'd0) ? ecol : ecol - 1'b1;
      total    = last_col - col + 1'b1;

      row_base = req_row_index * stride_ff;

      desc.start_addr = ADDR_W'(row_base) + ADDR_W'(col);
      desc.fill       = req_fill_word;
      if (single) begin
         desc.last_idx   = '0;
         desc.first_mask = single_mask;
         desc.last_mask  = single_mask;
      end else begin
         // spans longer than the write limit are cut; the cut-off write is a full word
         if (total > (X_W-5)'(MAX_WRITES)) begin
            desc.last_idx  = MAX_WRITES - 1'b1;
            desc.last_mask = FULL_MASK;
         end else begin
            desc.last_idx  = CNT_W'(total - 1'b1);
            desc.last_mask = (ebit != 5'd0) ? emask : FULL_MASK;
         end
         desc.first_mask = (sbit != 5'd0) ? smask : FULL_MASK;
      end

      desc_push = req_push && !queue_full && has_writes;
   end

endmodule

`default_nettype wire

[rtl/msf_queue.sv]
// Two-entry queue of span descriptors between front and back end.
// Depends on msf_pkg for the descriptor type.
`default_nettype none

module msf_queue
   import msf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire span_desc_type push_desc,
   input  wire logic          pop,
   output span_desc_type      head_desc,
   output logic               full,
   output logic               empty
);

   localparam int DEPTH = 2;

   span_desc_type entry_ff [DEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      full      = (count_ff == 2'(DEPTH));
      empty     = (count_ff == 2'd0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
      head_desc = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

[rtl/msf_back.sv]
// Back end: walks one span descriptor a word per cycle while each write is taken, and presents the writes.
// Depends on msf_pkg.
`default_nettype none

module msf_back
   import msf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_empty,
   input  wire span_desc_type q_desc,
   output logic               q_pop,
   input  wire logic          rsp_pop,
   output logic               rsp_empty,
   output logic [ADDR_W-1:0]  rsp_word_address,
   output logic [WORD_W-1:0]  rsp_write_mask,
   output logic [WORD_W-1:0]  rsp_write_data,
   output logic               rsp_last_write
);

   logic          busy_ff, busy_in;
   span_desc_type desc_ff;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic          is_last, taken, load;

   always_comb begin
      is_last = (idx_ff == desc_ff.last_idx);
      taken   = busy_ff && rsp_pop;
      load    = (!busy_ff || (taken && is_last)) && !q_empty;
      q_pop   = load;

      busy_in = busy_ff;
      idx_in  = idx_ff;
      addr_in = addr_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         addr_in = q_desc.start_addr;
      end else if (taken && is_last) begin
         busy_in = 1'b0;
      end else if (taken) begin
         idx_in  = idx_ff + 1'b1;
         addr_in = addr_ff + 1'b1;
      end

      rsp_empty        = !busy_ff;
      rsp_word_address = addr_ff;
      rsp_write_data   = desc_ff.fill;
      rsp_last_write   = is_last;
      if (idx_ff == '0) begin
         rsp_write_mask = desc_ff.first_mask;
      end else if (is_last) begin
         rsp_write_mask = desc_ff.last_mask;
      end else begin
         rsp_write_mask = FULL_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (load) begin
         desc_ff <= q_desc;
      end
   end

endmodule

`default_nettype wire

[rtl/masked_span_fill.sv]
// Masked span fill for a 1 bit per pixel bitmap. A span word is taken in every
// cycle the two-entry descriptor queue has room; spans that are off screen, on an
// absent row or reversed are dropped at once. The back end then issues one masked
// word write per cycle while rsp_pop takes it, so a span touching n bitmap words
// (1 to 13) occupies it for n writes; its word counter sets the sustained rate.
`default_nettype none

module masked_span_fill
   import msf_pkg::*;
#(
   parameter int SCREEN_WIDTH = 400,
   parameter int SCREEN_ROWS  = 240
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [ROW_W-1:0]      req_row_index,
   input  wire logic signed [X_W-1:0] req_x_start,
   input  wire logic signed [X_W-1:0] req_x_end,
   input  wire logic [WORD_W-1:0]     req_fill_word,
   input  wire logic                  rsp_pop,
   output logic                       rsp_empty,
   output logic [ADDR_W-1:0]          rsp_word_address,
   output logic [WORD_W-1:0]          rsp_write_mask,
   output logic [WORD_W-1:0]          rsp_write_data,
   output logic                       rsp_last_write,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [STRIDE_W-1:0]   csr_data
);

   span_desc_type new_desc, head_desc;
   logic          desc_push, q_full, q_empty, q_pop;

   assign req_full  = q_full;
   assign csr_ready = 1'b1;

   msf_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_ROWS  (SCREEN_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .queue_full    (q_full),
      .req_row_index (req_row_index),
      .req_x_start   (req_x_start),
      .req_x_end     (req_x_end),
      .req_fill_word (req_fill_word),
      .csr_valid     (csr_valid),
      .csr_data      (csr_data),
      .desc          (new_desc),
      .desc_push     (desc_push)
   );

   msf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (new_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   msf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_desc           (head_desc),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_word_address (rsp_word_address),
      .rsp_write_mask   (rsp_write_mask),
      .rsp_write_data   (rsp_write_data),
      .rsp_last_write   (rsp_last_write)
   );

   // a span does not end until its flagged word has gone
   a_span_continues: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_write) |=> !rsp_empty)
      else $error("span ended before its last word");

   a_addr_steps: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_write) |=>
         (rsp_word_address == ADDR_W'($past(rsp_word_address) + 1'b1)))
      else $error("word address did not advance by one within a span");

   // words in the middle of a span are full writes with unchanged data
   a_middle_full: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(!rsp_empty && rsp_pop && !rsp_last_write)
         && !rsp_last_write) |->
         (rsp_write_mask == FULL_MASK && rsp_write_data == $past(rsp_write_data)))
      else $error("inner word of a span is not a full write");

endmodule

`default_nettype wire
